[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define CPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define CPSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

[hdl/cpsc_pkg.sv]
// Types, codes and reset values of the charge port session controller.
package cpsc_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_PULSE = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PCLASS_NONE     = 2'd0,
    PCLASS_OVERLOAD = 2'd1,
    PCLASS_FULL     = 2'd2,
    PCLASS_NORMAL   = 2'd3
  } pclass_e;

  typedef enum logic [1:0] {
    STOP_QUOTA = 2'd0,
    STOP_TIME  = 2'd1,
    STOP_HOST  = 2'd2
  } stop_reason_e;

  typedef enum logic [2:0] {
    REG_OVERLOAD_GAP = 3'd0,
    REG_OVERLOAD_RUN = 3'd1,
    REG_FULL_GAP     = 3'd2,
    REG_FULL_RUN     = 3'd3,
    REG_PULSES_COIN  = 3'd4,
    REG_MS_COIN      = 3'd5,
    REG_REPORT_EVERY = 3'd6
  } reg_idx_e;

  localparam logic [15:0] OverloadGapRst = 16'd100;
  localparam logic [7:0]  OverloadRunRst = 8'd5;
  localparam logic [23:0] FullGapRst     = 24'd60000;
  localparam logic [7:0]  FullRunRst     = 8'd3;
  localparam logic [15:0] PulsesCoinRst  = 16'd100;
  localparam logic [23:0] MsCoinRst      = 24'd3600000;
  localparam logic [7:0]  ReportEveryRst = 8'd10;

  localparam logic [7:0] RunMax = 8'hff;

  typedef struct packed {
    logic [15:0] overload_gap_ms;
    logic [7:0]  overload_run_limit;
    logic [23:0] full_gap_ms;
    logic [7:0]  full_run_limit;
    logic [15:0] pulses_per_coin;
    logic [23:0] ms_per_coin;
    logic [7:0]  report_every_pulses;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       session_kind;
    logic [7:0] coins_paid;
  } in_item_t;

  typedef struct packed {
    logic        relay_on;
    logic        port_busy;
    logic        report_valid;
    logic        report_final;
    logic [31:0] pulse_total;
    logic [1:0]  pulse_class;
    logic        stop_valid;
    logic [1:0]  stop_reason;
  } out_item_t;

  // Session unit result for one beat.
  typedef struct packed {
    logic        busy;
    logic        report_valid;
    logic        report_final;
    logic [31:0] pulse_total;
    logic        stop_valid;
    logic [1:0]  stop_reason;
  } sess_res_t;

endpackage

[hdl/cpsc_apb_regs.sv]
// APB configuration registers of the charge port session controller.
module cpsc_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpsc_pkg::AddrW-1:0]   paddr,
  input  logic [cpsc_pkg::DataW-1:0]   pwdata,
  output logic [cpsc_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output cpsc_pkg::cfg_t               cfg_o
);

  cpsc_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overload_gap_ms     <= cpsc_pkg::OverloadGapRst;
      cfg_q.overload_run_limit  <= cpsc_pkg::OverloadRunRst;
      cfg_q.full_gap_ms         <= cpsc_pkg::FullGapRst;
      cfg_q.full_run_limit      <= cpsc_pkg::FullRunRst;
      cfg_q.pulses_per_coin     <= cpsc_pkg::PulsesCoinRst;
      cfg_q.ms_per_coin         <= cpsc_pkg::MsCoinRst;
      cfg_q.report_every_pulses <= cpsc_pkg::ReportEveryRst;
    end else if (wr_en) begin
      case (idx)
        cpsc_pkg::REG_OVERLOAD_GAP: cfg_q.overload_gap_ms     <= pwdata[15:0];
        cpsc_pkg::REG_OVERLOAD_RUN: cfg_q.overload_run_limit  <= pwdata[7:0];
        cpsc_pkg::REG_FULL_GAP:     cfg_q.full_gap_ms         <= pwdata[23:0];
        cpsc_pkg::REG_FULL_RUN:     cfg_q.full_run_limit      <= pwdata[7:0];
        cpsc_pkg::REG_PULSES_COIN:  cfg_q.pulses_per_coin     <= pwdata[15:0];
        cpsc_pkg::REG_MS_COIN:      cfg_q.ms_per_coin         <= pwdata[23:0];
        cpsc_pkg::REG_REPORT_EVERY: cfg_q.report_every_pulses <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cpsc_pkg::REG_OVERLOAD_GAP: prdata = {16'd0, cfg_q.overload_gap_ms};
      cpsc_pkg::REG_OVERLOAD_RUN: prdata = {24'd0, cfg_q.overload_run_limit};
      cpsc_pkg::REG_FULL_GAP:     prdata = {8'd0, cfg_q.full_gap_ms};
      cpsc_pkg::REG_FULL_RUN:     prdata = {24'd0, cfg_q.full_run_limit};
      cpsc_pkg::REG_PULSES_COIN:  prdata = {16'd0, cfg_q.pulses_per_coin};
      cpsc_pkg::REG_MS_COIN:      prdata = {8'd0, cfg_q.ms_per_coin};
      cpsc_pkg::REG_REPORT_EVERY: prdata = {24'd0, cfg_q.report_every_pulses};
      default:                    prdata = '0;
    endcase
  end

endmodule

[hdl/cpsc_gap.sv]
// Millisecond clock and meter pulse gap classifier.
module cpsc_gap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [2:0]         cmd_i,
  input  cpsc_pkg::cfg_t     cfg_i,
  output logic [1:0]         pulse_class_o
);

  logic [31:0] now_q, now_d;
  logic [31:0] last_q, last_d;
  logic [7:0]  short_q, short_d;
  logic [7:0]  long_q, long_d;
  logic [31:0] gap;

  assign gap = now_q - last_q;

  always_comb begin
    now_d         = now_q;
    last_d        = last_q;
    short_d       = short_q;
    long_d        = long_q;
    pulse_class_o = cpsc_pkg::PCLASS_NONE;
    case (cmd_i)
      cpsc_pkg::CMD_TICK: begin
        now_d = now_q + 32'd1;
      end
      cpsc_pkg::CMD_PULSE: begin
        last_d = now_q;
        if (gap < {16'd0, cfg_i.overload_gap_ms}) begin
          if (short_q != cpsc_pkg::RunMax) short_d = short_q + 8'd1;
          if (short_d > cfg_i.overload_run_limit) begin
            pulse_class_o = cpsc_pkg::PCLASS_OVERLOAD;
            short_d       = '0;
          end
        end else if (gap > {8'd0, cfg_i.full_gap_ms}) begin
          if (long_q != cpsc_pkg::RunMax) long_d = long_q + 8'd1;
          if (long_d > cfg_i.full_run_limit) begin
            pulse_class_o = cpsc_pkg::PCLASS_FULL;
            long_d        = '0;
          end
        end else begin
          // normal gap clears both runs
          short_d       = '0;
          long_d        = '0;
          pulse_class_o = cpsc_pkg::PCLASS_NORMAL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      last_q  <= '0;
      short_q <= '0;
      long_q  <= '0;
    end else if (fire_i) begin
      now_q   <= now_d;
      last_q  <= last_d;
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

endmodule

[hdl/cpsc_session.sv]
// Session state: pulse quota, coin timer, online reports and stop handling.
module cpsc_session (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  cpsc_pkg::in_item_t    item_i,
  input  cpsc_pkg::cfg_t        cfg_i,
  output cpsc_pkg::sess_res_t   res_o
);

  logic        active_q, active_d;
  logic        online_q, online_d;
  logic [7:0]  coins_q, coins_d;
  logic [31:0] pulses_q, pulses_d;
  logic [7:0]  rep_run_q, rep_run_d;
  logic [31:0] left_q, left_d;
  logic        timer_q, timer_d;
  logic [23:0] quota;
  logic [31:0] start_time;
  logic        stop;

  assign quota      = {16'd0, coins_q} * {8'd0, cfg_i.pulses_per_coin};
  assign start_time = {24'd0, item_i.coins_paid} * {8'd0, cfg_i.ms_per_coin};

  always_comb begin
    active_d  = active_q;
    online_d  = online_q;
    coins_d   = coins_q;
    pulses_d  = pulses_q;
    rep_run_d = rep_run_q;
    left_d    = left_q;
    timer_d   = timer_q;
    stop      = 1'b0;
    res_o     = '0;
    case (item_i.cmd)
      cpsc_pkg::CMD_TICK: begin
        if (timer_q) begin
          if (left_q <= 32'd1) begin
            left_d  = '0;
            timer_d = 1'b0;
            if (active_q && !online_q) begin
              stop              = 1'b1;
              res_o.stop_reason = cpsc_pkg::STOP_TIME;
            end
          end else begin
            left_d = left_q - 32'd1;
          end
        end
      end
      cpsc_pkg::CMD_PULSE: begin
        if (active_q) begin
          pulses_d = pulses_q + 32'd1;
          if (!online_q) begin
            if (pulses_d >= {8'd0, quota}) begin
              stop              = 1'b1;
              res_o.stop_reason = cpsc_pkg::STOP_QUOTA;
            end
          end else begin
            rep_run_d = rep_run_q + 8'd1;
            if (rep_run_d >= cfg_i.report_every_pulses) begin
              rep_run_d          = '0;
              res_o.report_valid = 1'b1;
            end
          end
        end
      end
      cpsc_pkg::CMD_START: begin
        // a start replaces any running session without a stop beat
        active_d = 1'b1;
        online_d = item_i.session_kind;
        coins_d  = item_i.coins_paid;
        pulses_d = '0;
        if (!item_i.session_kind) begin
          left_d  = start_time;
          timer_d = 1'b1;
        end else begin
          left_d  = '0;
          timer_d = 1'b0;
        end
      end
      cpsc_pkg::CMD_STOP: begin
        if (active_q) begin
          stop              = 1'b1;
          res_o.stop_reason = cpsc_pkg::STOP_HOST;
        end
      end
      default: ;
    endcase

    res_o.pulse_total = pulses_d;
    res_o.stop_valid  = stop;
    if (stop) begin
      if (online_d) begin
        res_o.report_valid = 1'b1;
        res_o.report_final = 1'b1;
      end
      active_d = 1'b0;
      online_d = 1'b0;
      coins_d  = '0;
      pulses_d = '0;
      timer_d  = 1'b0;
      left_d   = '0;
    end
    res_o.busy = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      online_q  <= 1'b0;
      coins_q   <= '0;
      pulses_q  <= '0;
      rep_run_q <= '0;
      left_q    <= '0;
      timer_q   <= 1'b0;
    end else if (fire_i) begin
      active_q  <= active_d;
      online_q  <= online_d;
      coins_q   <= coins_d;
      pulses_q  <= pulses_d;
      rep_run_q <= rep_run_d;
      left_q    <= left_d;
      timer_q   <= timer_d;
    end
  end

endmodule

[hdl/charge_port_session_controller.sv]
// Charge port session controller: input register, event logic, result register.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one event beat: a 1 ms
// tick, a meter pulse, a session start or a host stop. Every input beat gives
// exactly one result beat on out_valid_o/out_ready_i/out_data_o, in order,
// with relay level, busy flag, report, pulse class and stop fields.
// A beat accepted into the input register passes through the gap and session
// logic into the result register, which drives out_data_o. Throughput is one
// beat per cycle while the receiver takes results, set by the single pass of
// gap and session logic between the input register and the result register.
// When the receiver stalls, the result register holds; one more beat is taken
// into the input register, then in_ready_o drops until the result is taken.
// The APB port sets the seven configuration registers; write them only
// while no beat is in flight.
// Reset clears the ms clock, gap runs and session (relay off, idle) and loads
// the register defaults; no result is pending after reset.
module charge_port_session_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cpsc_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cpsc_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpsc_pkg::AddrW-1:0]  paddr,
  input  logic [cpsc_pkg::DataW-1:0]  pwdata,
  output logic [cpsc_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  cpsc_pkg::cfg_t      cfg;
  cpsc_pkg::in_item_t  in_q;
  cpsc_pkg::out_item_t out_q, out_d;
  cpsc_pkg::sess_res_t sess;
  logic                in_vld_q;
  logic                out_vld_q;
  logic                fire;
  logic [1:0]          pclass;

  // process the held beat when the result register is free or draining
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  cpsc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cpsc_gap u_gap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .cmd_i         (in_q.cmd),
    .cfg_i         (cfg),
    .pulse_class_o (pclass)
  );

  cpsc_session u_sess (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (sess)
  );

  always_comb begin
    out_d.relay_on     = sess.busy;
    out_d.port_busy    = sess.busy;
    out_d.report_valid = sess.report_valid;
    out_d.report_final = sess.report_final;
    out_d.pulse_total  = sess.pulse_total;
    out_d.pulse_class  = pclass;
    out_d.stop_valid   = sess.stop_valid;
    out_d.stop_reason  = sess.stop_reason;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (fire) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[hdl/cpsc_checker.sv]
// Port-level checker for the charge port session controller, with its bind.
`include "assert_macros.svh"

module cpsc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cpsc_pkg::out_item_t out_data_o
);

  `CPSC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result beat changed")
  `CPSC_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with no pending result")
  `CPSC_ASSERT(a_relay_busy, out_valid_o |-> out_data_o.relay_on == out_data_o.port_busy, "relay level differs from busy")
  `CPSC_ASSERT(a_stop_idle, out_valid_o && out_data_o.stop_valid |-> !out_data_o.port_busy && !out_data_o.relay_on, "port still busy after a stop")
  `CPSC_ASSERT(a_final_rep, out_valid_o && out_data_o.report_final |-> out_data_o.report_valid && out_data_o.stop_valid, "final report without stop")

endmodule

bind charge_port_session_controller cpsc_checker u_cpsc_checker (.*);

[tb/charge_port_session_controller_test.sv]
// Testbench for the charge port session controller: directed table, random phases, checks.
module charge_port_session_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpsc_pkg::*;

  typedef enum int {FLOW_FREE, FLOW_SENDER, FLOW_RECEIVER, FLOW_BOTH} flow_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic       kind;
    logic [7:0] coins;
    logic       typed;
    out_item_t  want;
  } step_row_t;

  // Highest cmd code; everything above CMD_QUERY is unused.
  localparam logic [2:0] CmdMax = 3'd7;
  localparam int unsigned PlanRows = 26;
  localparam int unsigned PhaseCount = 7;

  localparam out_item_t IdleResult = '0;
  localparam out_item_t TimeStop =
    '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, PCLASS_NONE, 1'b1, STOP_TIME};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  in_item_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b1;
  out_item_t       out_data_o;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic            pready;

  charge_port_session_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Port model state and configuration
  cfg_t        port_cfg = '{OverloadGapRst, OverloadRunRst, FullGapRst, FullRunRst,
                            PulsesCoinRst, MsCoinRst, ReportEveryRst};
  logic [31:0] clock_ms = '0;
  logic [31:0] prev_pulse_ms = '0;
  logic [7:0]  short_run = '0;
  logic [7:0]  long_run = '0;
  logic        charging = 1'b0;
  logic        card_session = 1'b0;
  logic [7:0]  paid_coins = '0;
  logic [31:0] pulse_count = '0;
  logic [7:0]  report_count = '0;
  logic [31:0] ms_remaining = '0;
  logic        countdown_on = 1'b0;

  out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;

  step_row_t plan [PlanRows] = '{
    '{CMD_QUERY, 1'b0, 8'd0,   1'b1, IdleResult},
    '{CMD_STOP,  1'b1, 8'd255, 1'b1, IdleResult},
    '{CmdMax,    1'b1, 8'd255, 1'b1, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_START, 1'b0, 8'd1,   1'b0, IdleResult},
    '{CMD_TICK,  1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_TICK,  1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_START, 1'b0, 8'd255, 1'b0, IdleResult},
    '{CMD_TICK,  1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_START, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_TICK,  1'b0, 8'd0,   1'b1, TimeStop},
    '{CMD_START, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_START, 1'b1, 8'd0,   1'b0, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_START, 1'b0, 8'd1,   1'b0, IdleResult},
    '{CMD_START, 1'b1, 8'd7,   1'b0, IdleResult},
    '{CMD_TICK,  1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_TICK,  1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_TICK,  1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_PULSE, 1'b0, 8'd0,   1'b0, IdleResult},
    '{CMD_STOP,  1'b0, 8'd0,   1'b0, IdleResult}
  };

  function automatic out_item_t next_port_result(in_item_t ev);
    out_item_t   r;
    logic [31:0] gap;
    logic [31:0] quota;
    r = '0;
    case (ev.cmd)
      CMD_TICK: begin
        clock_ms = clock_ms + 32'd1;
        if (countdown_on) begin
          if (ms_remaining <= 32'd1) begin
            ms_remaining = '0;
            countdown_on = 1'b0;
            if (charging && !card_session) begin
              r.stop_valid = 1'b1;
              r.stop_reason = STOP_TIME;
            end
          end else begin
            ms_remaining = ms_remaining - 32'd1;
          end
        end
      end
      CMD_PULSE: begin
        gap = clock_ms - prev_pulse_ms;
        if (gap < port_cfg.overload_gap_ms) begin
          if (short_run < RunMax) short_run = short_run + 8'd1;
          if (short_run > port_cfg.overload_run_limit) begin
            r.pulse_class = PCLASS_OVERLOAD;
            short_run = '0;
          end
        end else if (gap > port_cfg.full_gap_ms) begin
          if (long_run < RunMax) long_run = long_run + 8'd1;
          if (long_run > port_cfg.full_run_limit) begin
            r.pulse_class = PCLASS_FULL;
            long_run = '0;
          end
        end else begin
          short_run = '0;
          long_run = '0;
          r.pulse_class = PCLASS_NORMAL;
        end
        prev_pulse_ms = clock_ms;
        if (charging) begin
          pulse_count = pulse_count + 32'd1;
          if (!card_session) begin
            quota = paid_coins * port_cfg.pulses_per_coin;
            if (pulse_count >= quota) begin
              r.stop_valid = 1'b1;
              r.stop_reason = STOP_QUOTA;
            end
          end else begin
            report_count = report_count + 8'd1;
            if (report_count >= port_cfg.report_every_pulses) begin
              report_count = '0;
              r.report_valid = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        charging = 1'b1;
        card_session = ev.session_kind;
        paid_coins = ev.coins_paid;
        pulse_count = '0;
        if (!card_session) begin
          ms_remaining = paid_coins * port_cfg.ms_per_coin;
          countdown_on = 1'b1;
        end else begin
          ms_remaining = '0;
          countdown_on = 1'b0;
        end
      end
      CMD_STOP: begin
        if (charging) begin
          r.stop_valid = 1'b1;
          r.stop_reason = STOP_HOST;
        end
      end
      default: ;
    endcase
    r.pulse_total = pulse_count;
    if (r.stop_valid) begin
      if (card_session) begin
        r.report_valid = 1'b1;
        r.report_final = 1'b1;
      end
      charging = 1'b0;
      card_session = 1'b0;
      paid_coins = '0;
      pulse_count = '0;
      countdown_on = 1'b0;
      ms_remaining = '0;
    end
    r.relay_on = charging;
    r.port_busy = charging;
    return r;
  endfunction

  function automatic logic [31:0] cfg_field(cfg_t c, reg_idx_e idx);
    case (idx)
      REG_OVERLOAD_GAP: return 32'(c.overload_gap_ms);
      REG_OVERLOAD_RUN: return 32'(c.overload_run_limit);
      REG_FULL_GAP:     return 32'(c.full_gap_ms);
      REG_FULL_RUN:     return 32'(c.full_run_limit);
      REG_PULSES_COIN:  return 32'(c.pulses_per_coin);
      REG_MS_COIN:      return 32'(c.ms_per_coin);
      default:          return 32'(c.report_every_pulses);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic int idle_cycles(int pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("relay_on", want.relay_on, out_data_o.relay_on);
        check_field("port_busy", want.port_busy, out_data_o.port_busy);
        check_field("report_valid", want.report_valid, out_data_o.report_valid);
        check_field("report_final", want.report_final, out_data_o.report_final);
        check_field("pulse_total", want.pulse_total, out_data_o.pulse_total);
        check_field("pulse_class", want.pulse_class, out_data_o.pulse_class);
        check_field("stop_valid", want.stop_valid, out_data_o.stop_valid);
        check_field("stop_reason", want.stop_reason, out_data_o.stop_reason);
      end
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(reg_idx_e idx, output logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic verify_registers();
    logic [31:0] rd;
    reg_idx_e    idx;
    for (int i = REG_OVERLOAD_GAP; i <= REG_REPORT_EVERY; i++) begin
      idx = reg_idx_e'(i);
      apb_read(idx, rd);
      check_field(idx.name(), cfg_field(port_cfg, idx), rd);
    end
  endtask

  task automatic apply_cfg(cfg_t c);
    for (int i = REG_OVERLOAD_GAP; i <= REG_REPORT_EVERY; i++) begin
      apb_write(reg_idx_e'(i), cfg_field(c, reg_idx_e'(i)));
    end
    port_cfg = c;
    verify_registers();
  endtask

  task automatic set_flow(flow_e f);
    sender_idle_pct = (f == FLOW_SENDER) ? 78 : (f == FLOW_BOTH) ? 14 : 0;
    receiver_stall_pct = (f == FLOW_RECEIVER) ? 78 : (f == FLOW_BOTH) ? 14 : 0;
  endtask

  // Hold the beat until accepted, then queue its expected result.
  task automatic send_event(in_item_t ev, logic typed, out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = idle_cycles(sender_idle_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = next_port_result(ev);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and let every result drain before touching the registers.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    int       done;
    int       burst;
    int       pick;
    in_item_t ev;
    done = 0;
    burst = 0;
    while (done < count) begin
      ev.session_kind = 1'($urandom_range(1));
      ev.coins_paid = 8'($urandom_range(255));
      if (burst > 0) begin
        ev.cmd = CMD_TICK;
        burst--;
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          ev.cmd = CMD_TICK;
          // stretch the gap so long-gap runs build up
          if ($urandom_range(9) == 0) burst = $urandom_range(30, 3);
        end else if (pick < 78) begin
          ev.cmd = CMD_PULSE;
        end else if (pick < 86) begin
          ev.cmd = CMD_START;
          if ($urandom_range(9) != 0) ev.coins_paid = 8'($urandom_range(3));
        end else if (pick < 92) begin
          ev.cmd = CMD_STOP;
        end else begin
          ev.cmd = 3'($urandom_range(CmdMax, CMD_QUERY));
        end
      end
      send_event(ev, 1'b0, IdleResult);
      if (ev.cmd <= CMD_STOP) done++;
    end
  endtask

  initial begin : stimulus
    cfg_t     phase_cfg [PhaseCount];
    flow_e    phase_flow [PhaseCount];
    int       phase_items [PhaseCount];
    in_item_t ev;

    phase_cfg[0] = '{OverloadGapRst, OverloadRunRst, FullGapRst, FullRunRst,
                     PulsesCoinRst, MsCoinRst, ReportEveryRst};
    phase_cfg[1] = '{16'd3, 8'd2, 24'd8, 8'd1, 16'd5, 24'd20, 8'd3};
    phase_cfg[2] = '{16'hffff, 8'hff, 24'hffffff, 8'hff, 16'hffff, 24'hffffff, 8'hff};
    phase_cfg[3] = '0;
    phase_cfg[4] = '{16'd2, 8'd0, 24'd5, 8'd2, 16'd1, 24'd4, 8'd1};
    for (int p = 5; p < PhaseCount; p++) begin
      phase_cfg[p].overload_gap_ms = 16'($urandom_range(6));
      phase_cfg[p].overload_run_limit = 8'($urandom_range(3));
      phase_cfg[p].full_gap_ms = 24'($urandom_range(20));
      phase_cfg[p].full_run_limit = 8'($urandom_range(3));
      phase_cfg[p].pulses_per_coin = 16'($urandom_range(8));
      phase_cfg[p].ms_per_coin = 24'($urandom_range(40));
      phase_cfg[p].report_every_pulses = 8'($urandom_range(5));
    end
    phase_flow = '{FLOW_FREE, FLOW_SENDER, FLOW_RECEIVER, FLOW_BOTH,
                   FLOW_FREE, FLOW_SENDER, FLOW_BOTH};
    phase_items = '{120, 140, 130, 140, 140, 130, 130};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    verify_registers();
    apply_cfg('{16'd2, 8'd1, 24'd3, 8'd0, 16'd2, 24'd3, 8'd2});
    set_flow(FLOW_FREE);
    foreach (plan[i]) begin
      ev.cmd = plan[i].cmd;
      ev.session_kind = plan[i].kind;
      ev.coins_paid = plan[i].coins;
      send_event(ev, plan[i].typed, plan[i].want);
    end
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      apply_cfg(phase_cfg[p]);
      set_flow(phase_flow[p]);
      run_random(phase_items[p]);
      drain();
    end

    set_flow(FLOW_FREE);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
